[hw/rtl/cta_pkg.sv]
// ----------------------------------------------------------------------------
// cta_pkg
// Shared types and constants for the connection table with aging.
// ----------------------------------------------------------------------------
package cta_pkg;

    localparam logic [1:0] REQ_CONNECT    = 2'd0;
    localparam logic [1:0] REQ_DISCONNECT = 2'd1;
    localparam logic [1:0] REQ_TICK       = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_CMP,
        S_MOVE,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture a new request
        logic conn_write; // append entry, count up
        logic rd_last;    // read address is the last live slot
        logic idx_inc;    // advance walk index
        logic drop;       // count down, no move
        logic move;       // write last entry into the hole, count down
        logic set_ok;     // mark result successful
    } cta_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       idx_end;
        logic       idx_last;
        logic       hit;
    } cta_status_t;

endpackage

[hw/rtl/cta_ram.sv]
// ----------------------------------------------------------------------------
// cta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cta_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/cta_ctrl.sv]
// ----------------------------------------------------------------------------
// cta_ctrl
// Request sequencer: decode, table walk, move-last removal, result strobe.
// ----------------------------------------------------------------------------
module cta_ctrl
    import cta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cta_status_t status,
    output cta_cmd_t    cmd,
    output logic        busy,
    output logic        result_valid
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        busy         = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.req == REQ_CONNECT)
                begin
                    if (!status.full)
                    begin
                        cmd.conn_write = 1'b1;
                        cmd.set_ok     = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (status.req == REQ_DISCONNECT)
                begin
                    state_next = S_RD;
                end
                else if (status.req == REQ_TICK)
                begin
                    cmd.set_ok = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                state_next = status.idx_end ? S_DONE : S_CMP;
            end
            S_CMP:
            begin
                cmd.rd_last = 1'b1;
                if (status.hit)
                begin
                    if (status.req == REQ_DISCONNECT)
                    begin
                        cmd.set_ok = 1'b1;
                    end
                    if (status.idx_last)
                    begin
                        cmd.drop   = 1'b1;
                        state_next = (status.req == REQ_DISCONNECT) ? S_DONE : S_RD;
                    end
                    else
                    begin
                        state_next = S_MOVE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = (status.req == REQ_DISCONNECT) ? S_DONE : S_RD;
            end
            S_DONE:
            begin
                result_valid = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/cta_datapath.sv]
// ----------------------------------------------------------------------------
// cta_datapath
// Table storage, count, clock, timeout register and slot compare logic.
// ----------------------------------------------------------------------------
module cta_datapath
    import cta_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  req_type,
    input  logic [31:0] device_id,
    input  logic [31:0] tick_count,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    input  cta_cmd_t    cmd,
    output cta_status_t status,
    output logic        ok,
    output logic [4:0]  live_count
);

    logic [1:0]       req_reg;
    logic [31:0]      id_reg;
    logic [31:0]      now_reg;
    logic [31:0]      timeout_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             ok_reg;

    logic [CNT_W-1:0] last_idx;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [63:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [63:0]      ram_rdata;
    logic [31:0]      age;
    logic [31:0]      count_ext;

    assign last_idx = count_reg - CNT_W'(1);
    assign age      = now_reg - ram_rdata[31:0];

    always_comb
    begin
        ram_we    = cmd.conn_write | cmd.move;
        ram_waddr = cmd.conn_write ? count_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        ram_wdata = cmd.conn_write ? {id_reg, now_reg} : ram_rdata;
        ram_raddr = cmd.rd_last ? last_idx[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    end

    cta_ram #(
        .WIDTH (64),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            now_reg     <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                timeout_reg <= cfg_data;
            end
            if (cmd.latch && req_type == REQ_TICK)
            begin
                now_reg <= now_reg + tick_count;
            end
            if (cmd.conn_write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.drop || cmd.move)
            begin
                count_reg <= last_idx;
            end
        end
    end

    // request payload and walk state
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_type;
            id_reg  <= device_id;
            idx_reg <= '0;
            ok_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.set_ok)
            begin
                ok_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        status.req      = req_reg;
        status.full     = (count_reg == CNT_W'(CAPACITY));
        status.idx_end  = (idx_reg >= count_reg);
        status.idx_last = (idx_reg == last_idx);
        status.hit      = (req_reg == REQ_DISCONNECT) ? (ram_rdata[63:32] == id_reg)
                                                      : (age >= timeout_reg);
    end

    assign count_ext  = 32'(count_reg);
    assign ok         = ok_reg;
    assign live_count = count_ext[4:0];

endmodule

[hw/rtl/connection_table_with_aging_top.sv]
// ----------------------------------------------------------------------------
// connection_table_with_aging_top
// Device connection table with append, move-last removal and timeout aging.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a transaction is taken on a clock edge with start high
//   and busy low; req_type selects connect (0), disconnect (1) or tick (2).
//   Result channel: result_valid pulses for one cycle with ok and live_count;
//   the receiver cannot stall, so the result must be sampled on that cycle.
//   Config channel: cfg_valid/cfg_ready write timeout_ticks; cfg_ready is
//   always high. Write only while the block is idle.
// Sequence (states from accept to the result cycle):
//   connect and unused codes: decode, then result.
//   disconnect/tick: the table walk reads then compares each slot; a removal
//   adds a move (or a drop for the last slot), set by the single read port of
//   the entry RAM and its registered read.
// Busy: busy stays high through the result cycle, so the next request
//   is taken in the cycle after it at the earliest.
// Reset: entry count and current time clear, timeout returns to 1000.
//   Entry storage is not cleared; only slots below the count are read.
// ----------------------------------------------------------------------------
module connection_table_with_aging_top
    import cta_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] device_id,
    input  logic [31:0] tick_count,
    // result
    output logic        result_valid,
    output logic        ok,
    output logic [4:0]  live_count,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    cta_cmd_t    cmd;
    cta_status_t status;

    // Config writes are accepted at any time; the user keeps them to idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    cta_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    cta_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .device_id  (device_id),
        .tick_count (tick_count),
        .cfg_write  (cfg_valid & cfg_ready),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .ok         (ok),
        .live_count (live_count)
    );

endmodule
